// ===== rtl/kvbep_pkg.sv =====
// Shared constants and codes for the kv block eviction policy unit.
`timescale 1ns / 1ps

package kvbep_pkg;

    localparam int TABLE_DEPTH_DEF = 4096;
    localparam int MAX_SELECT_DEF  = 16;
    localparam int ID_BITS_DEF     = 16;

    localparam logic [15:0] DECAY_DEFAULT = 16'd62259;
    localparam logic [24:0] RECENCY_ONE   = 25'd16777216;
    localparam logic [24:0] EPS_Q24       = 25'd17;

    localparam logic [2:0] OP_TRACK  = 3'd0;
    localparam logic [2:0] OP_TOUCH  = 3'd1;
    localparam logic [2:0] OP_TICK   = 3'd2;
    localparam logic [2:0] OP_DROP   = 3'd3;
    localparam logic [2:0] OP_SELECT = 3'd4;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_FULL     = 2'd1;
    localparam logic [1:0] ST_DUP      = 2'd2;
    localparam logic [1:0] ST_NOTFOUND = 2'd3;

endpackage

// ===== rtl/kv_block_eviction_policy_unit.sv =====
// Top level of the recency and importance weighted eviction table.
`timescale 1ns / 1ps

// Usage:
//   An item (req_type, entry tag, importance, select_count) is taken when
//   start is high and busy is low. busy stays high while a table pass runs.
//   Results appear on the o_ result ports for one cycle with o_strobe high;
//   the receiver cannot stall, so every result is taken as it appears.
//   o_last_of_run marks the final result of an item.
//   Track, touch and drop scan the table once for the tag and answer when
//   the scan ends; a drop that finds its tag then copies the last entry
//   into the freed slot. A full-table track answers without a scan.
//   Tick walks every entry through the shared multiplier.
//   Select makes one full pass per victim and reports each victim as its
//   pass ends. Other items answer without a table pass.
//   Every pass streams the table memory through a 3-stage read, multiply,
//   compare path at one entry per cycle.
//   i_cfg_we writes the decay register (Q0.16, zero means 0.95); write it
//   only while the block is idle.
//   Reset empties the table and loads decay 0.95; the table memories need
//   no clearing.
module kv_block_eviction_policy_unit
    import kvbep_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int MAX_SELECT  = MAX_SELECT_DEF,
    parameter int ID_BITS     = ID_BITS_DEF,
    localparam int CNT_W      = $clog2(TABLE_DEPTH + 1),
    localparam int IDX_W      = $clog2(TABLE_DEPTH),
    localparam int SEL_W      = $clog2(MAX_SELECT + 1)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [2:0]         i_req_type,
    input  logic [15:0]        i_entry_tag,
    input  logic signed [15:0] i_importance,
    input  logic [4:0]         i_select_count,
    input  logic               i_cfg_we,
    input  logic [15:0]        i_cfg_wdata,
    output logic               o_strobe,
    output logic [1:0]         o_status,
    output logic [15:0]        o_victim_id,
    output logic               o_victim_valid,
    output logic               o_last_of_run,
    output logic [CNT_W-1:0]   o_entry_count
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DRD  = 2'd2;
    localparam logic [1:0] S_DWR  = 2'd3;

    logic [ID_BITS-1:0] id_mem  [TABLE_DEPTH];
    logic [14:0]        imp_mem [TABLE_DEPTH];
    logic [24:0]        rec_mem [TABLE_DEPTH];

    logic [ID_BITS-1:0] r_rd_id;
    logic [14:0]        r_rd_imp;
    logic [24:0]        r_rd_rec;

    logic [1:0]         r_state;
    logic [15:0]        r_decay;
    logic [CNT_W-1:0]   r_count;
    logic [2:0]         r_op;
    logic [ID_BITS-1:0] r_id;
    logic [14:0]        r_imp;
    logic [SEL_W-1:0]   r_want;
    logic [SEL_W-1:0]   r_k;
    logic [CNT_W-1:0]   r_idx;
    logic               r_v1;
    logic [IDX_W-1:0]   r_i1;
    logic               r_v2;
    logic [IDX_W-1:0]   r_i2;
    logic [ID_BITS-1:0] r_id2;
    logic [41:0]        r_prod;
    logic               r_found;
    logic [IDX_W-1:0]   r_pos;
    logic               r_bvalid;
    logic [41:0]        r_bkey;
    logic [IDX_W-1:0]   r_bidx;
    logic [ID_BITS-1:0] r_bid;
    logic               r_has_prev;
    logic [41:0]        r_pkey;
    logic [IDX_W-1:0]   r_pidx;

    logic [IDX_W-1:0]   mem_ra;
    logic               we_id, we_imp, we_rec;
    logic [IDX_W-1:0]   waddr;
    logic [ID_BITS-1:0] wd_id;
    logic [14:0]        wd_imp;
    logic [24:0]        wd_rec;
    logic [25:0]        mul_a;
    logic [15:0]        mul_b;
    logic [15:0]        decay_eff;
    logic               issue;
    logic               scan_done;
    logic [24:0]        tick_val;
    logic               qualify;
    logic [CNT_W-1:0]   last_idx;
    logic [6:0]         cnt_sat;
    logic [6:0]         want_full;
    logic               accept;

    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign decay_eff = (r_decay == 16'd0) ? DECAY_DEFAULT : r_decay;
    assign issue     = (r_state == S_SCAN) && (r_idx < r_count);
    assign scan_done = (r_state == S_SCAN) && !issue && !r_v1 && !r_v2;
    assign last_idx  = r_count - CNT_W'(1);
    assign mem_ra    = (r_state == S_DRD) ? last_idx[IDX_W-1:0] : r_idx[IDX_W-1:0];
    assign tick_val  = r_prod[40:16];

    assign cnt_sat   = (7'(i_select_count) > 7'(MAX_SELECT)) ? 7'(MAX_SELECT)
                                                              : 7'(i_select_count);
    assign want_full = (32'(cnt_sat) > 32'(r_count)) ? 7'(r_count) : cnt_sat;

    // shared multiplier: tick decay or select key
    always_comb begin
        if (r_op == OP_TICK) begin
            mul_a = {1'b0, r_rd_rec};
            mul_b = decay_eff;
        end else begin
            mul_a = 26'(r_rd_rec) + 26'(EPS_Q24);
            mul_b = 16'd256 + 16'(r_rd_imp);
        end
    end

    assign qualify = !r_has_prev || (r_prod > r_pkey)
                     || ((r_prod == r_pkey) && (r_i2 > r_pidx));

    always_comb begin
        we_id  = 1'b0;
        we_imp = 1'b0;
        we_rec = 1'b0;
        waddr  = r_pos;
        wd_id  = r_id;
        wd_imp = r_imp;
        wd_rec = RECENCY_ONE;
        if (r_state == S_SCAN && r_op == OP_TICK && r_v2) begin
            we_rec = 1'b1;
            waddr  = r_i2;
            wd_rec = (tick_val < EPS_Q24) ? 25'd0 : tick_val;
        end else if (scan_done && r_op == OP_TRACK && !r_found) begin
            we_id  = 1'b1;
            we_imp = 1'b1;
            we_rec = 1'b1;
            waddr  = r_count[IDX_W-1:0];
        end else if (scan_done && r_op == OP_TOUCH && r_found) begin
            we_rec = 1'b1;
        end else if (r_state == S_DWR) begin
            we_id  = 1'b1;
            we_imp = 1'b1;
            we_rec = 1'b1;
            wd_id  = r_rd_id;
            wd_imp = r_rd_imp;
            wd_rec = r_rd_rec;
        end
    end

    always_ff @(posedge i_clk) begin
        if (we_id) begin
            id_mem[waddr] <= wd_id;
        end
        if (we_imp) begin
            imp_mem[waddr] <= wd_imp;
        end
        if (we_rec) begin
            rec_mem[waddr] <= wd_rec;
        end
        r_rd_id  <= id_mem[mem_ra];
        r_rd_imp <= imp_mem[mem_ra];
        r_rd_rec <= rec_mem[mem_ra];
    end

    // datapath pipeline: read, multiply, compare
    always_ff @(posedge i_clk) begin
        r_i1   <= r_idx[IDX_W-1:0];
        r_i2   <= r_i1;
        r_id2  <= r_rd_id;
        r_prod <= 42'(mul_a) * 42'(mul_b);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_decay        <= DECAY_DEFAULT;
            r_count        <= '0;
            r_v1           <= 1'b0;
            r_v2           <= 1'b0;
            o_strobe       <= 1'b0;
            o_status       <= ST_OK;
            o_victim_id    <= '0;
            o_victim_valid <= 1'b0;
            o_last_of_run  <= 1'b0;
            o_entry_count  <= '0;
        end else begin
            o_strobe <= 1'b0;
            r_v1     <= issue;
            r_v2     <= r_v1 && (r_state == S_SCAN);
            if (i_cfg_we) begin
                r_decay <= i_cfg_wdata;
            end
            if (issue) begin
                r_idx <= r_idx + CNT_W'(1);
            end
            if (r_state == S_SCAN && r_v1 && r_rd_id == r_id && !r_found) begin
                r_found <= 1'b1;
                r_pos   <= r_i1;
            end
            if (r_state == S_SCAN && r_op == OP_SELECT && r_v2 && qualify
                && (!r_bvalid || r_prod < r_bkey)) begin
                r_bvalid <= 1'b1;
                r_bkey   <= r_prod;
                r_bidx   <= r_i2;
                r_bid    <= r_id2;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op       <= i_req_type;
                        r_id       <= ID_BITS'(i_entry_tag);
                        r_imp      <= i_importance[15] ? 15'd0 : i_importance[14:0];
                        r_want     <= SEL_W'(want_full);
                        r_k        <= '0;
                        r_idx      <= '0;
                        r_found    <= 1'b0;
                        r_bvalid   <= 1'b0;
                        r_has_prev <= 1'b0;
                        o_status       <= ST_OK;
                        o_victim_id    <= '0;
                        o_victim_valid <= 1'b0;
                        o_last_of_run  <= 1'b1;
                        o_entry_count  <= r_count;
                        priority if (i_req_type == OP_TRACK
                                     && 32'(r_count) >= TABLE_DEPTH) begin
                            o_strobe <= 1'b1;
                            o_status <= ST_FULL;
                        end else if (i_req_type == OP_SELECT && want_full == 7'd0) begin
                            o_strobe <= 1'b1;
                        end else if (i_req_type <= OP_SELECT) begin
                            r_state <= S_SCAN;
                        end else begin
                            o_strobe <= 1'b1;
                        end
                    end
                end
                S_SCAN: begin
                    if (scan_done) begin
                        o_status       <= ST_OK;
                        o_victim_id    <= '0;
                        o_victim_valid <= 1'b0;
                        o_last_of_run  <= 1'b1;
                        o_entry_count  <= r_count;
                        r_state        <= S_IDLE;
                        unique case (r_op)
                            OP_TRACK: begin
                                o_strobe <= 1'b1;
                                if (r_found) begin
                                    o_status <= ST_DUP;
                                end else begin
                                    r_count       <= r_count + CNT_W'(1);
                                    o_entry_count <= r_count + CNT_W'(1);
                                end
                            end
                            OP_TOUCH: begin
                                o_strobe <= 1'b1;
                                o_status <= r_found ? ST_OK : ST_NOTFOUND;
                            end
                            OP_DROP: begin
                                if (r_found) begin
                                    r_state <= S_DRD;
                                end else begin
                                    o_strobe <= 1'b1;
                                    o_status <= ST_NOTFOUND;
                                end
                            end
                            OP_SELECT: begin
                                o_strobe       <= 1'b1;
                                o_victim_id    <= 16'(r_bid);
                                o_victim_valid <= 1'b1;
                                o_last_of_run  <= (r_k + SEL_W'(1) == r_want);
                                r_k            <= r_k + SEL_W'(1);
                                r_has_prev     <= 1'b1;
                                r_pkey         <= r_bkey;
                                r_pidx         <= r_bidx;
                                r_bvalid       <= 1'b0;
                                r_idx          <= '0;
                                if (r_k + SEL_W'(1) != r_want) begin
                                    r_state <= S_SCAN;
                                end
                            end
                            default: begin
                                o_strobe <= 1'b1;
                            end
                        endcase
                    end
                end
                S_DRD: begin
                    r_state <= S_DWR;
                end
                default: begin
                    r_count        <= last_idx;
                    o_strobe       <= 1'b1;
                    o_status       <= ST_OK;
                    o_victim_id    <= '0;
                    o_victim_valid <= 1'b0;
                    o_last_of_run  <= 1'b1;
                    o_entry_count  <= last_idx;
                    r_state        <= S_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= TABLE_DEPTH)
        else $error("entry count above table depth");
    a_victim_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_victim_valid && o_strobe |-> o_status == ST_OK)
        else $error("victim with bad status");
    a_run_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_last_of_run |-> busy)
        else $error("run ended without last result");
`endif

endmodule

// ===== tb/kv_block_eviction_policy_unit_tb.sv =====
// Self-checking testbench for the kv block eviction policy unit.
`timescale 1ns / 1ps

module kv_block_eviction_policy_unit_tb;
    import kvbep_pkg::*;

    localparam int DEPTH   = 4096;
    localparam int MAX_SEL = 16;

    typedef struct {
        logic [2:0]         op;
        logic [15:0]        id;
        logic signed [15:0] imp;
        logic [4:0]         cnt;
    } t_request;

    typedef struct {
        logic [1:0]  status;
        logic [15:0] victim_id;
        logic        victim_valid;
        logic        last;
        logic [12:0] count;
    } t_outcome;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic               busy;
    logic [2:0]         i_req_type = '0;
    logic [15:0]        i_entry_tag = '0;
    logic signed [15:0] i_importance = '0;
    logic [4:0]         i_select_count = '0;
    logic               i_cfg_we = 1'b0;
    logic [15:0]        i_cfg_wdata = '0;
    logic               o_strobe;
    logic [1:0]         o_status;
    logic [15:0]        o_victim_id;
    logic               o_victim_valid;
    logic               o_last_of_run;
    logic [12:0]        o_entry_count;

    kv_block_eviction_policy_unit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_req_type     (i_req_type),
        .i_entry_tag    (i_entry_tag),
        .i_importance   (i_importance),
        .i_select_count (i_select_count),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_victim_id    (o_victim_id),
        .o_victim_valid (o_victim_valid),
        .o_last_of_run  (o_last_of_run),
        .o_entry_count  (o_entry_count)
    );

    always #10 i_clk = ~i_clk;

    // shadow table
    logic [15:0] tbl_id  [DEPTH];
    logic [14:0] tbl_imp [DEPTH];
    logic [24:0] tbl_rec [DEPTH];
    logic        taken   [DEPTH];
    int          tbl_count = 0;
    logic [15:0] decay_reg = DECAY_DEFAULT;

    t_request pending_items[$];
    t_outcome expected_results[$];
    int       gap_left = 0;
    int       gap_max = 6;
    int       errors = 0;

    function automatic int find_slot(logic [15:0] id);
        for (int i = 0; i < tbl_count; i++)
            if (tbl_id[i] == id) return i;
        return -1;
    endfunction

    function automatic logic [63:0] victim_key(int i);
        return (64'(tbl_rec[i]) + 64'(EPS_Q24)) * (64'd256 + 64'(tbl_imp[i]));
    endfunction

    task automatic push_outcome(logic [1:0] st, logic [15:0] vid, logic v, logic l);
        t_outcome o;
        o.status = st; o.victim_id = vid; o.victim_valid = v; o.last = l;
        o.count = 13'(tbl_count);
        expected_results.push_back(o);
    endtask

    task automatic apply_request(t_request r);
        int          pos;
        int          want;
        int          best;
        logic [63:0] best_key;
        logic [63:0] kv;
        logic [40:0] prod;
        logic [15:0] d;
        logic [1:0]  st;
        st = ST_OK;
        case (r.op)
            OP_TRACK: begin
                if (tbl_count >= DEPTH) st = ST_FULL;
                else if (find_slot(r.id) >= 0) st = ST_DUP;
                else begin
                    tbl_id[tbl_count]  = r.id;
                    tbl_imp[tbl_count] = r.imp[15] ? 15'd0 : r.imp[14:0];
                    tbl_rec[tbl_count] = RECENCY_ONE;
                    tbl_count++;
                end
            end
            OP_TOUCH: begin
                pos = find_slot(r.id);
                if (pos < 0) st = ST_NOTFOUND;
                else tbl_rec[pos] = RECENCY_ONE;
            end
            OP_TICK: begin
                d = (decay_reg == 16'd0) ? DECAY_DEFAULT : decay_reg;
                for (int i = 0; i < tbl_count; i++) begin
                    prod = 41'(tbl_rec[i]) * 41'(d);
                    tbl_rec[i] = (prod[40:16] < EPS_Q24) ? 25'd0 : prod[40:16];
                end
            end
            OP_DROP: begin
                pos = find_slot(r.id);
                if (pos < 0) st = ST_NOTFOUND;
                else begin
                    tbl_id[pos]  = tbl_id[tbl_count-1];
                    tbl_imp[pos] = tbl_imp[tbl_count-1];
                    tbl_rec[pos] = tbl_rec[tbl_count-1];
                    tbl_count--;
                end
            end
            OP_SELECT: begin
                want = (r.cnt > MAX_SEL) ? MAX_SEL : int'(r.cnt);
                if (want > tbl_count) want = tbl_count;
                for (int i = 0; i < tbl_count; i++) taken[i] = 1'b0;
                for (int k = 0; k < want; k++) begin
                    best = -1;
                    best_key = '0;
                    for (int i = 0; i < tbl_count; i++) begin
                        if (taken[i]) continue;
                        kv = victim_key(i);
                        if (best < 0 || kv < best_key) begin
                            best = i;
                            best_key = kv;
                        end
                    end
                    taken[best] = 1'b1;
                    push_outcome(ST_OK, tbl_id[best], 1'b1, k + 1 == want);
                end
                if (want > 0) return;
            end
            default: ;
        endcase
        push_outcome(st, 16'd0, 1'b0, 1'b1);
    endtask

    // driver
    always @(posedge i_clk) begin
        logic     take;
        logic     nxt;
        t_request r;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            take = start && !busy;
            nxt = start;
            if (take) begin
                r.op = i_req_type; r.id = i_entry_tag;
                r.imp = i_importance; r.cnt = i_select_count;
                apply_request(r);
            end
            if (take || !start) begin
                nxt = 1'b0;
                if (gap_left > 0) begin
                    gap_left--;
                end else if (pending_items.size() > 0) begin
                    r = pending_items.pop_front();
                    i_req_type     <= r.op;
                    i_entry_tag    <= r.id;
                    i_importance   <= r.imp;
                    i_select_count <= r.cnt;
                    nxt = 1'b1;
                    gap_left = $urandom_range(0, gap_max);
                end
            end
            start <= nxt;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_outcome e;
        if (i_rst_n && o_strobe) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result, status %0d victim %0h", o_status, o_victim_id);
                errors++;
            end else begin
                e = expected_results.pop_front();
                if (o_status !== e.status) begin
                    $error("status: expected %0d, got %0d", e.status, o_status);
                    errors++;
                end
                if (o_victim_id !== e.victim_id) begin
                    $error("victim_id: expected %0h, got %0h", e.victim_id, o_victim_id);
                    errors++;
                end
                if (o_victim_valid !== e.victim_valid) begin
                    $error("victim_valid: expected %0d, got %0d",
                           e.victim_valid, o_victim_valid);
                    errors++;
                end
                if (o_last_of_run !== e.last) begin
                    $error("last_of_run: expected %0d, got %0d", e.last, o_last_of_run);
                    errors++;
                end
                if (o_entry_count !== e.count) begin
                    $error("entry_count: expected %0d, got %0d", e.count, o_entry_count);
                    errors++;
                end
            end
        end
    end

    task automatic queue_item(logic [2:0] op, logic [15:0] id, logic [15:0] imp,
                              logic [4:0] cnt);
        t_request r;
        r.op = op; r.id = id; r.imp = imp; r.cnt = cnt;
        pending_items.push_back(r);
    endtask

    task automatic drain;
        while (pending_items.size() > 0 || start || expected_results.size() > 0 || busy)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_decay(logic [15:0] v);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        decay_reg = v;
    endtask

    task automatic queue_random(int n);
        int          pick;
        logic [15:0] id;
        for (int k = 0; k < n; k++) begin
            pick = $urandom_range(0, 99);
            id = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 23));
            if (pick < 30)      queue_item(OP_TRACK, id, 16'($urandom), 5'($urandom));
            else if (pick < 45) queue_item(OP_TOUCH, id, 16'($urandom), 5'($urandom));
            else if (pick < 58) queue_item(OP_TICK, id, 16'($urandom), 5'($urandom));
            else if (pick < 73) queue_item(OP_DROP, id, 16'($urandom), 5'($urandom));
            else if (pick < 95) queue_item(OP_SELECT, id, 16'($urandom),
                                           5'($urandom_range(0, 31)));
            else // unused op codes
                queue_item(3'($urandom_range(5, 7)), id, 16'($urandom), 5'($urandom));
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed
        queue_item(OP_SELECT, 16'd0, 16'd0, 5'd5);
        queue_item(OP_TICK, 16'd0, 16'd0, 5'd0);
        queue_item(OP_TOUCH, 16'd7, 16'd0, 5'd0);
        queue_item(OP_DROP, 16'd7, 16'd0, 5'd0);
        queue_item(3'd5, 16'hFFFF, 16'hFFFF, 5'd31);
        queue_item(3'd6, 16'd0, 16'd0, 5'd0);
        queue_item(3'd7, 16'hAAAA, 16'h5555, 5'd10);
        queue_item(OP_TRACK, 16'd0, 16'h7FFF, 5'd0);
        queue_item(OP_TRACK, 16'hFFFF, 16'h8000, 5'd31);
        queue_item(OP_TRACK, 16'd0, 16'd5, 5'd0);
        queue_item(OP_TRACK, 16'h1234, 16'hFFFF, 5'd0);
        queue_item(OP_TRACK, 16'h00FF, 16'h0100, 5'd0);
        queue_item(OP_TICK, 16'd0, 16'd0, 5'd0);
        queue_item(OP_TOUCH, 16'hFFFF, 16'd0, 5'd0);
        queue_item(OP_SELECT, 16'd0, 16'd0, 5'd0);
        queue_item(OP_SELECT, 16'd0, 16'd0, 5'd31);
        queue_item(OP_SELECT, 16'd0, 16'd0, 5'd2);
        queue_item(OP_DROP, 16'd0, 16'd0, 5'd0);
        queue_item(OP_SELECT, 16'd0, 16'd0, 5'd16);
        drain();

        write_decay(16'd0);
        queue_item(OP_TICK, 16'd0, 16'd0, 5'd0);
        queue_item(OP_SELECT, 16'd0, 16'd0, 5'd3);
        drain();

        write_decay(16'd1);
        queue_item(OP_TICK, 16'd0, 16'd0, 5'd0);
        queue_item(OP_TICK, 16'd0, 16'd0, 5'd0);
        queue_item(OP_SELECT, 16'd0, 16'd0, 5'd4);
        drain();

        write_decay(16'hFFFF);
        queue_random(32);
        drain();

        gap_max = 0;
        write_decay(DECAY_DEFAULT);
        queue_random(32);
        drain();

        gap_max = 6;
        write_decay(16'($urandom_range(1, 65535)));
        queue_random(32);
        drain();

        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial begin
        #(64'd600_000_000);
        $display("FAILURE");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/kvbep_pkg.sv
rtl/kv_block_eviction_policy_unit.sv
tb/kv_block_eviction_policy_unit_tb.sv
